// ----- design/retab_pkg.sv -----
`timescale 1ns / 1ps
package retab_pkg;

	localparam int POSITIONS = 4096;
	localparam int TBL_AW    = $clog2(POSITIONS);

	localparam int POS_W       = 12;
	localparam int REACT_W     = 16;
	localparam int ENERGY_W    = 12;
	localparam int CFG_W       = 12;
	localparam int IN_DATA_W   = 32;
	localparam int OUT_DATA_W  = 16;

	localparam int QDEPTH = 2;
	localparam int QAW    = $clog2(QDEPTH);

	localparam int FRAC      = 60;
	localparam int HALF      = FRAC / 2;
	localparam int LNV_W     = 63;
	localparam int DEN_W     = 17;
	localparam int TERMS     = 40;
	localparam int TERM_W    = $clog2(TERMS);
	localparam int DIV_CNT_W = $clog2(FRAC);

	localparam logic [FRAC-1:0] LN2_Q60 = 60'hB17217F7D1CF79A;

	localparam logic [0:0] CFG_LOOKUP_EN  = 1'b0;
	localparam logic [0:0] CFG_SEQ_LENGTH = 1'b1;

	typedef enum logic {
		REQ_LOAD   = 1'b0,
		REQ_LOOKUP = 1'b1
	} req_t;

	typedef enum logic {
		ST_OK      = 1'b0,
		ST_IGNORED = 1'b1
	} status_t;

	typedef struct packed {
		req_t               req;
		logic [POS_W-1:0]   pos;
		logic [REACT_W-1:0] react;
		logic               store_ok;
		logic               in_table;
	} cmd_t;

	typedef struct packed {
		logic               start;
		logic [REACT_W-1:0] react;
	} log_req_t;

	typedef struct packed {
		logic                done;
		logic [ENERGY_W-1:0] energy;
	} log_rsp_t;

endpackage

// ----- design/retab_front.sv -----
`timescale 1ns / 1ps
module retab_front (
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [retab_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // position, reactivity
	input  logic [0:0]                       s_axis_tuser,  // req_type
	input  logic [retab_pkg::POS_W-1:0]      seq_length,
	input  logic                             clearing,
	input  logic                             q_full,
	output logic                             q_push,
	output retab_pkg::cmd_t                  q_din
);
	import retab_pkg::*;

	logic [POS_W-1:0]   pos;
	logic [REACT_W-1:0] react;
	logic               in_table;

	assign pos      = s_axis_tdata[POS_W-1:0];
	assign react    = s_axis_tdata[POS_W +: REACT_W];
	assign in_table = (32'(pos) < POSITIONS);

	assign s_axis_tready = !clearing && !q_full;
	assign q_push        = s_axis_tvalid && s_axis_tready;

	always_comb begin
		q_din.req      = req_t'(s_axis_tuser[0]);
		q_din.pos      = pos;
		q_din.react    = react;
		q_din.in_table = in_table;
		q_din.store_ok = in_table && (pos <= seq_length);
	end

endmodule

// ----- design/retab_fifo.sv -----
`timescale 1ns / 1ps
module retab_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  retab_pkg::cmd_t din,
	output logic            full,
	input  logic            pop,
	output retab_pkg::cmd_t dout,
	output logic            empty
);
	import retab_pkg::*;

	cmd_t           entry_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= din;
		end
	end

	assign dout  = entry_q[rd_ptr_q];
	assign full  = (cnt_q == (QAW+1)'(QDEPTH));
	assign empty = (cnt_q == '0);

endmodule

// ----- design/retab_log.sv -----
`timescale 1ns / 1ps
module retab_log (
	input  logic                clk,
	input  logic                arst_n,
	input  retab_pkg::log_req_t req,
	output retab_pkg::log_rsp_t rsp
);
	import retab_pkg::*;

	localparam int LNV_SHIFT = 12;
	localparam int OUT_POS   = 48;
	localparam int RND_POS   = OUT_POS - 1;
	localparam int V_W       = OUT_POS + ENERGY_W + 1;
	localparam int L12_W     = LNV_W - LNV_SHIFT;
	localparam logic [2:0] MUL_LAST = 3'd4;
	localparam logic [TERM_W-1:0] I_LAST = TERM_W'(TERMS - 1);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(FRAC - 1);
	localparam logic [ENERGY_W:0] ENERGY_OFS = (ENERGY_W+1)'(80);

	typedef enum logic [5:0] {
		L_IDLE = 6'b000001,
		L_ZDIV = 6'b000010,
		L_MUL  = 6'b000100,
		L_TDIV = 6'b001000,
		L_FIN1 = 6'b010000,
		L_FIN2 = 6'b100000
	} lstate_t;

	lstate_t state_q;
	lstate_t state_nx;
	logic    done_q;

	logic                  miss_q;
	logic [LNV_W-1:0]      kln2_q;
	logic [DEN_W-1:0]      den_q;
	logic [DEN_W-1:0]      rem_q;
	logic [FRAC-1:0]       dq_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic [FRAC-1:0]       z_q;
	logic [FRAC-1:0]       z2_q;
	logic [FRAC-1:0]       t_q;
	logic [FRAC-1:0]       sum_q;
	logic [TERM_W-1:0]     i_q;
	logic                  sq_q;
	logic [2:0]            mc_q;
	logic [2*FRAC-1:0]     acc_q;
	logic [2*HALF-1:0]     prod_s1;
	logic [LNV_W-1:0]      lnv_q;
	logic [ENERGY_W-1:0]   energy_q;

	// range reduction
	logic [REACT_W-1:0] n;
	logic [REACT_W-1:0] p;
	logic [REACT_W-1:0] num;
	logic [DEN_W-1:0]   den;
	logic [2:0]         kk;
	logic [LNV_W-1:0]   ln2_w;
	logic [LNV_W-1:0]   kln2;

	always_comb begin
		n  = req.react + REACT_W'(256);
		kk = '0;
		for (int j = 8; j < REACT_W; j++) begin
			if (n[j]) begin
				kk = 3'(j - 8);
			end
		end
		p     = REACT_W'(256) << kk;
		num   = n - p;
		den   = DEN_W'(n) + DEN_W'(p);
		ln2_w = LNV_W'(LN2_Q60);
		kln2  = (kk[0] ? ln2_w : '0) + (kk[1] ? (ln2_w << 1) : '0)
		      + (kk[2] ? (ln2_w << 2) : '0);
	end

	// shift-subtract divider, one quotient bit per cycle
	logic [DEN_W:0]   trial;
	logic             ge;
	logic [DEN_W-1:0] rem_nx;
	logic [FRAC-1:0]  dq_nx;
	logic             div_last;

	always_comb begin
		trial    = {rem_q, dq_q[FRAC-1]};
		ge       = (trial >= {1'b0, den_q});
		rem_nx   = ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
		dq_nx    = {dq_q[FRAC-2:0], ge};
		div_last = (cnt_q == DIV_LAST);
	end

	// Q0.60 multiply from four 30x30 partial products
	logic [FRAC-1:0]   ma;
	logic [FRAC-1:0]   mb;
	logic [HALF-1:0]   a_h;
	logic [HALF-1:0]   b_h;
	logic [2*HALF-1:0] prod;
	logic [2*FRAC-1:0] addend;
	logic [2*FRAC-1:0] acc_nx;
	logic [FRAC-1:0]   mul_res;

	always_comb begin
		ma = sq_q ? z_q : t_q;
		mb = sq_q ? z_q : z2_q;
		case (mc_q[1:0])
			2'd0: begin
				a_h = ma[HALF-1:0];
				b_h = mb[HALF-1:0];
			end
			2'd1: begin
				a_h = ma[HALF-1:0];
				b_h = mb[FRAC-1:HALF];
			end
			2'd2: begin
				a_h = ma[FRAC-1:HALF];
				b_h = mb[HALF-1:0];
			end
			default: begin
				a_h = ma[FRAC-1:HALF];
				b_h = mb[FRAC-1:HALF];
			end
		endcase
		prod = a_h * b_h;
		case (mc_q)
			3'd1: addend = (2*FRAC)'(prod_s1);
			3'd2, 3'd3: addend = (2*FRAC)'(prod_s1) << HALF;
			3'd4: addend = (2*FRAC)'(prod_s1) << FRAC;
			default: addend = '0;
		endcase
		acc_nx  = acc_q + addend;
		mul_res = acc_nx[2*FRAC-1:FRAC];
	end

	// final scaling and rounding
	logic [L12_W-1:0] l12;
	logic [V_W-1:0]   v;

	always_comb begin
		l12 = lnv_q[LNV_W-1:LNV_SHIFT];
		v   = (V_W'(l12) << 8) + (V_W'(l12) << 2) + (V_W'(1) << RND_POS);
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			L_IDLE: begin
				if (req.start) begin
					state_nx = (req.react[REACT_W-1] || n == p) ? L_FIN1 : L_ZDIV;
				end
			end
			L_ZDIV: begin
				if (div_last) begin
					state_nx = L_MUL;
				end
			end
			L_MUL: begin
				if (mc_q == MUL_LAST && !sq_q) begin
					state_nx = (mul_res == '0) ? L_FIN1 : L_TDIV;
				end
			end
			L_TDIV: begin
				if (div_last) begin
					state_nx = (i_q == I_LAST) ? L_FIN1 : L_MUL;
				end
			end
			L_FIN1: state_nx = L_FIN2;
			L_FIN2: state_nx = L_IDLE;
			default: state_nx = L_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			done_q  <= (state_q == L_FIN2);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			L_IDLE: begin
				if (req.start) begin
					miss_q <= req.react[REACT_W-1];
					kln2_q <= kln2;
					sum_q  <= '0;
					rem_q  <= DEN_W'(num);
					den_q  <= den;
					dq_q   <= '0;
					cnt_q  <= '0;
				end
			end
			L_ZDIV: begin
				rem_q <= rem_nx;
				dq_q  <= dq_nx;
				cnt_q <= cnt_q + 1'b1;
				if (div_last) begin
					z_q   <= dq_nx;
					t_q   <= dq_nx;
					sum_q <= dq_nx;
					sq_q  <= 1'b1;
					mc_q  <= '0;
					acc_q <= '0;
					i_q   <= TERM_W'(1);
				end
			end
			L_MUL: begin
				if (mc_q != MUL_LAST) begin
					prod_s1 <= prod;
					acc_q   <= acc_nx;
					mc_q    <= mc_q + 1'b1;
				end else begin
					mc_q  <= '0;
					acc_q <= '0;
					if (sq_q) begin
						z2_q <= mul_res;
						sq_q <= 1'b0;
					end else begin
						t_q   <= mul_res;
						rem_q <= '0;
						dq_q  <= mul_res;
						den_q <= DEN_W'({i_q, 1'b1});
						cnt_q <= '0;
					end
				end
			end
			L_TDIV: begin
				rem_q <= rem_nx;
				dq_q  <= dq_nx;
				cnt_q <= cnt_q + 1'b1;
				if (div_last) begin
					sum_q <= sum_q + dq_nx;
					i_q   <= i_q + 1'b1;
				end
			end
			L_FIN1: begin
				lnv_q <= kln2_q + LNV_W'({sum_q, 1'b0});
			end
			L_FIN2: begin
				energy_q <= miss_q ? '0 : ENERGY_W'(v[V_W-1:OUT_POS] - ENERGY_OFS);
			end
			default: ;
		endcase
	end

	assign rsp.done   = done_q;
	assign rsp.energy = energy_q;

endmodule

// ----- design/retab_back.sv -----
`timescale 1ns / 1ps
module retab_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              lookup_en,
	input  logic                              q_empty,
	input  retab_pkg::cmd_t                   q_dout,
	output logic                              q_pop,
	output logic                              clearing,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [retab_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // energy
	output logic [0:0]                        m_axis_tuser   // status
);
	import retab_pkg::*;

	typedef enum logic [4:0] {
		B_CLEAR = 5'b00001,
		B_IDLE  = 5'b00010,
		B_READ  = 5'b00100,
		B_CALC  = 5'b01000,
		B_EMIT  = 5'b10000
	} bstate_t;

	localparam logic [TBL_AW-1:0] CLR_LAST = TBL_AW'(POSITIONS - 1);

	bstate_t             state_q;
	logic [TBL_AW-1:0]   clr_cnt_q;
	logic                out_vld_q;
	cmd_t                cmd_q;
	logic [ENERGY_W-1:0] res_energy_q;
	status_t             res_status_q;
	logic [ENERGY_W-1:0] out_energy_q;
	status_t             out_status_q;

	logic [ENERGY_W-1:0] table_q [POSITIONS];
	logic [ENERGY_W-1:0] rd_q;
	logic                we;
	logic [TBL_AW-1:0]   wa;
	logic [ENERGY_W-1:0] wd;
	logic [TBL_AW-1:0]   ra;

	log_req_t lreq;
	log_rsp_t lrsp;
	logic     emit;

	retab_log u_log (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (lreq),
		.rsp    (lrsp)
	);

	assign clearing   = (state_q == B_CLEAR);
	assign q_pop      = (state_q == B_IDLE) && !q_empty;
	assign lreq.start = q_pop && (q_dout.req == REQ_LOAD);
	assign lreq.react = q_dout.react;
	assign emit       = (state_q == B_EMIT) && (!out_vld_q || m_axis_tready);

	always_comb begin
		ra = TBL_AW'(q_dout.pos);
		if (clearing) begin
			we = 1'b1;
			wa = clr_cnt_q;
			wd = '0;
		end else begin
			we = (state_q == B_CALC) && lrsp.done && cmd_q.store_ok;
			wa = TBL_AW'(cmd_q.pos);
			wd = lrsp.energy;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			table_q[wa] <= wd;
		end
		rd_q <= table_q[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_CLEAR;
			clr_cnt_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			case (state_q)
				B_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == CLR_LAST) begin
						state_q <= B_IDLE;
					end
				end
				B_IDLE: begin
					if (!q_empty) begin
						state_q <= (q_dout.req == REQ_LOOKUP) ? B_READ : B_CALC;
					end
				end
				B_READ: state_q <= B_EMIT;
				B_CALC: begin
					if (lrsp.done) begin
						state_q <= B_EMIT;
					end
				end
				B_EMIT: begin
					if (emit) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_dout;
		end
		if (state_q == B_READ) begin
			res_energy_q <= (lookup_en && cmd_q.in_table) ? rd_q : '0;
			res_status_q <= ST_OK;
		end
		if (state_q == B_CALC && lrsp.done) begin
			res_energy_q <= lrsp.energy;
			res_status_q <= cmd_q.store_ok ? ST_OK : ST_IGNORED;
		end
		if (emit) begin
			out_energy_q <= res_energy_q;
			out_status_q <= res_status_q;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = OUT_DATA_W'(out_energy_q);
	assign m_axis_tuser  = out_status_q;

endmodule

// ----- design/reactivity_energy_table_core.sv -----
`timescale 1ns / 1ps
// Per-position pseudo-energy table: a load beat turns a Q8.8 reactivity into
// round(100*(2.6*ln(x+1)-0.8)) in hundredths of kcal/mol (0 for negative,
// missing data) and stores it when the position is within seq_length; a lookup
// beat returns the stored term, or 0 while lookups are disabled (register 0 low).
// Every input beat gives one output beat, in order. After reset the table is
// swept to zero, one entry per cycle, across all 4096 entries with s_axis_tready
// low; config writes are taken during that time. Items pass through a two-entry
// queue and are worked one at a time; a stalled output holds the back end. A
// lookup reads the stored term; a load with negative reactivity or with x+1 an
// exact power of two skips the log series. Any other load runs the log unit: a
// 60-bit shift-subtract divide and two multiplies built from 30x30 partial
// products, then per further atanh series term another divide and multiply,
// until a term is zero or the TERMS limit is reached.
module reactivity_energy_table_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [retab_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // position, reactivity
	input  logic [0:0]                        s_axis_tuser,   // req_type
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [retab_pkg::OUT_DATA_W-1:0]  m_axis_tdata,   // energy
	output logic [0:0]                        m_axis_tuser,   // status
	input  logic                              cfg_we,
	input  logic [0:0]                        cfg_index,
	input  logic [retab_pkg::CFG_W-1:0]       cfg_data
);
	import retab_pkg::*;

	logic             shape_en_q;
	logic [POS_W-1:0] seq_len_q;

	logic clearing;
	logic q_full;
	logic q_push;
	logic q_pop;
	logic q_empty;
	cmd_t q_din;
	cmd_t q_dout;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_en_q <= 1'b0;
			seq_len_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LOOKUP_EN: shape_en_q <= cfg_data[0];
				CFG_SEQ_LENGTH: seq_len_q <= cfg_data[POS_W-1:0];
				default: ;
			endcase
		end
	end

	retab_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.seq_length    (seq_len_q),
		.clearing      (clearing),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_din         (q_din)
	);

	retab_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_dout),
		.empty  (q_empty)
	);

	retab_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.lookup_en     (shape_en_q),
		.q_empty       (q_empty),
		.q_dout        (q_dout),
		.q_pop         (q_pop),
		.clearing      (clearing),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule
